/* rtl/dvd_pkg.sv */
// dvd_pkg: widths, datapath operation codes and controller states for the
// 128-bit signed/unsigned divider. No dependencies.
package dvd_pkg;

  localparam int unsigned WordW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned CntW  = $clog2(WordW);

  typedef logic [WordW-1:0] word_t;
  typedef logic [HalfW-1:0] half_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam cnt_t LastStep = cnt_t'(WordW - 1);

  // one command per cycle from the controller to the datapath
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_NEG_N,
    OP_NEG_D,
    OP_STEP,
    OP_NEG_Q,
    OP_NEG_R,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEG_N,
    S_NEG_D,
    S_DIV,
    S_NEG_Q,
    S_NEG_R,
    S_OUT
  } dvd_state_t;

endpackage

/* rtl/dvd_in_if.sv */
// dvd_in_if: operand channel of the divider (valid/ready plus payload)
// depends on dvd_pkg
interface dvd_in_if;
  import dvd_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  half_t dividend_hi;
  half_t dividend_lo;
  half_t divisor_hi;
  half_t divisor_lo;

  modport source (output valid, output cmd, output dividend_hi, output dividend_lo,
                  output divisor_hi, output divisor_lo, input ready);
  modport sink   (input valid, input cmd, input dividend_hi, input dividend_lo,
                  input divisor_hi, input divisor_lo, output ready);
endinterface

/* rtl/dvd_out_if.sv */
// dvd_out_if: result channel of the divider (valid/ready plus payload)
// depends on dvd_pkg
interface dvd_out_if;
  import dvd_pkg::*;

  logic  valid;
  logic  ready;
  half_t quotient_hi;
  half_t quotient_lo;
  half_t remainder_hi;
  half_t remainder_lo;

  modport source (output valid, output quotient_hi, output quotient_lo,
                  output remainder_hi, output remainder_lo, input ready);
  modport sink   (input valid, input quotient_hi, input quotient_lo,
                  input remainder_hi, input remainder_lo, output ready);
endinterface

/* rtl/dvd_dp.sv */
// dvd_dp: divider datapath - operand/quotient shift register, partial
// remainder, one shared 128-bit negator and the result register; uses dvd_pkg
module dvd_dp (
  input  logic            clk,
  input  dvd_pkg::dp_op_t op,
  input  logic            cmd,
  input  dvd_pkg::word_t  dividend,
  input  dvd_pkg::word_t  divisor,
  output dvd_pkg::word_t  quotient,
  output dvd_pkg::word_t  remainder
);
  import dvd_pkg::*;

  word_t n_r, n_nxt;      // dividend, shifted out as quotient bits shift in
  word_t d_r, d_nxt;
  word_t acc_r, acc_nxt;  // partial remainder
  logic  sgn_r, sgn_nxt;
  logic  nneg_r, nneg_nxt;
  logic  dneg_r, dneg_nxt;
  word_t q_out_r, q_out_nxt;
  word_t r_out_r, r_out_nxt;

  word_t              neg_src;
  word_t              neg_res;
  logic [WordW:0]     acc_sh;
  logic [WordW:0]     diff;
  logic               fits;

  // shared negator operand select
  always_comb begin
    case (op)
      OP_NEG_D: neg_src = d_r;
      OP_NEG_R: neg_src = acc_r;
      default:  neg_src = n_r;
    endcase
  end

  assign neg_res = ~neg_src + word_t'(1);

  // restoring step: acc_sh < 2*d, so a 129-bit difference keeps the sign
  assign acc_sh = {acc_r, n_r[WordW-1]};
  assign diff   = acc_sh - {1'b0, d_r};
  assign fits   = ~diff[WordW];

  always_comb begin
    n_nxt     = n_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    sgn_nxt   = sgn_r;
    nneg_nxt  = nneg_r;
    dneg_nxt  = dneg_r;
    q_out_nxt = q_out_r;
    r_out_nxt = r_out_r;
    unique case (op)
      OP_LOAD: begin
        n_nxt    = dividend;
        d_nxt    = divisor;
        acc_nxt  = '0;
        sgn_nxt  = cmd;
        nneg_nxt = cmd & dividend[WordW-1];
        dneg_nxt = cmd & divisor[WordW-1];
      end
      OP_NEG_N: if (nneg_r) n_nxt = neg_res;
      OP_NEG_D: if (dneg_r) d_nxt = neg_res;
      OP_STEP: begin
        n_nxt   = {n_r[WordW-2:0], fits};
        acc_nxt = fits ? diff[WordW-1:0] : acc_sh[WordW-1:0];
      end
      OP_NEG_Q: if (sgn_r && (nneg_r != dneg_r)) n_nxt = neg_res;
      OP_NEG_R: if (nneg_r) acc_nxt = neg_res;
      OP_EMIT: begin
        q_out_nxt = n_r;
        r_out_nxt = acc_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    acc_r   <= acc_nxt;
    sgn_r   <= sgn_nxt;
    nneg_r  <= nneg_nxt;
    dneg_r  <= dneg_nxt;
    q_out_r <= q_out_nxt;
    r_out_r <= r_out_nxt;
  end

  assign quotient  = q_out_r;
  assign remainder = r_out_r;

endmodule

/* rtl/dvd_ctrl.sv */
// dvd_ctrl: divider sequencer - state machine, step counter and result valid
// uses dvd_pkg; drives dvd_dp through dp_op_t commands
module dvd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dvd_pkg::dp_op_t op
);
  import dvd_pkg::*;

  dvd_state_t state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       ovld_r, ovld_nxt;
  logic       slot_free;

  assign slot_free = ~ovld_r | out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_NEG_N;
      S_NEG_N: state_nxt = S_NEG_D;
      S_NEG_D: state_nxt = S_DIV;
      S_DIV:   if (cnt_r == LastStep) state_nxt = S_NEG_Q;
      S_NEG_Q: state_nxt = S_NEG_R;
      S_NEG_R: state_nxt = S_OUT;
      S_OUT:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      S_NEG_N: op = OP_NEG_N;
      S_NEG_D: op = OP_NEG_D;
      S_DIV:   op = OP_STEP;
      S_NEG_Q: op = OP_NEG_Q;
      S_NEG_R: op = OP_NEG_R;
      S_OUT:   if (slot_free) op = OP_EMIT;
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt  = (state_r == S_DIV) ? cnt_r + cnt_t'(1) : '0;
    ovld_nxt = (op == OP_EMIT) ? 1'b1 : (ovld_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_valid = ovld_r;

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_DIV |-> cnt_r == '0)
    else $error("step counter not clear outside division");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == LastStep) |=> state_r == S_NEG_Q)
    else $error("division did not end after the last step");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_NEG_N)
    else $error("accepted transfer did not start a division");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_EMIT |=> ovld_r)
    else $error("result loaded but not flagged valid");

endmodule

/* rtl/divider_128bit_signed_unsigned_top.sv */
// divider_128bit_signed_unsigned_top: 128-bit signed/unsigned divider top level
// depends on dvd_pkg, dvd_in_if, dvd_out_if, dvd_ctrl, dvd_dp
//
// Restoring radix-2 divider for 128-bit operands, giving quotient and
// remainder together. cmd = 0 divides unsigned, cmd = 1 divides signed with
// truncation: the core divides magnitudes, the quotient is negated when the
// operand signs differ and the remainder takes the dividend's sign. A zero
// divisor yields an all-ones unsigned quotient (sign rule applied in signed
// mode) and the dividend as remainder. One operand transfer is taken at a
// time. The operands load at the accepting edge itself, then the sequencer
// runs operand sign fix-up (dividend, then divisor) on a shared 128-bit
// negator, the shift-subtract loop (one quotient bit per cycle, using a
// 129-bit subtract), result sign fix-up (quotient, then remainder) and the
// load of the output register. The sequencer returns to idle at the same
// edge that loads the output register, so it can accept the next operand
// transfer while that result is offered. The
// output register is separate from the working registers, so a new operand
// transfer can be accepted while the previous result still waits; the
// sequencer only stalls in its last step if that older result has not been
// taken yet.
module divider_128bit_signed_unsigned_top (
  input  logic      clk,
  input  logic      rst_n,
  dvd_in_if.sink    in_ch,
  dvd_out_if.source out_ch
);
  import dvd_pkg::*;

  dp_op_t op;
  word_t  dividend;
  word_t  divisor;
  word_t  quotient;
  word_t  remainder;

  // reassemble 128-bit operands from the 64-bit halves
  assign dividend = {in_ch.dividend_hi, in_ch.dividend_lo};
  assign divisor  = {in_ch.divisor_hi, in_ch.divisor_lo};

  // sequencer: owns state, step count and the result valid flag
  dvd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .op        (op)
  );

  // datapath: operands, partial remainder, negator, result register
  dvd_dp u_dp (
    .clk       (clk),
    .op        (op),
    .cmd       (in_ch.cmd),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // split results back into halves
  assign out_ch.quotient_hi  = quotient[WordW-1:HalfW];
  assign out_ch.quotient_lo  = quotient[HalfW-1:0];
  assign out_ch.remainder_hi = remainder[WordW-1:HalfW];
  assign out_ch.remainder_lo = remainder[HalfW-1:0];

endmodule
